FILE: design/vtt_pkg.sv
// ============================================================================
// vtt_pkg
// Shared types and constants of the text terminal: field widths, parser
// modes, byte classes, the queue item and the state codes of the back end.
// ============================================================================
package vtt_pkg;

  // Default grid size.
  localparam int ROW_COUNT_DEF = 12;
  localparam int COL_COUNT_DEF = 45;

  // Port field widths.
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 6;
  localparam int MODE_W = 2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Tab stops fall on multiples of this power of two.
  localparam int TAB_STOP  = 4;
  localparam int TAB_SHIFT = $clog2(TAB_STOP);

  // Parameters saturate at this value.
  localparam logic [15:0] PARAM_MAX = 16'hFFFF;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_FIN_HI = 8'h7E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;
  localparam logic [7:0] CH_HOME   = 8'h48;
  localparam logic [7:0] CH_HOME_F = 8'h66;
  localparam logic [7:0] CH_ERASE  = 8'h4A;
  localparam logic [7:0] CH_ERLINE = 8'h4B;

  // Parser modes, as reported on the result channel.
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2,
    MODE_OSC    = 2'd3
  } mode_t;

  // Byte classes worked out by the front end.
  typedef enum logic [3:0] {
    CLS_CR,
    CLS_LF,
    CLS_BS,
    CLS_TAB,
    CLS_ESC,
    CLS_BEL,
    CLS_CTRL,
    CLS_DIGIT,
    CLS_SEMI,
    CLS_FINAL,
    CLS_PRINT
  } byte_cls_t;

  // One request as it travels through the queue.
  typedef struct packed {
    logic              is_read;
    logic [CHAR_W-1:0] data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    byte_cls_t         cls;
  } item_t;

  // Back end states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RDDATA,
    BK_SCRRD,
    BK_SCRWR,
    BK_FILL,
    BK_PUT,
    BK_DONE
  } bk_state_t;

endpackage

FILE: design/vtt_front.sv
// ============================================================================
// vtt_front
// Accepts requests, classifies host bytes and holds them in a short queue
// from which the back end takes them.
// ============================================================================
module vtt_front
  import vtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [CHAR_W-1:0] in_data_byte,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic [COL_W-1:0]  in_read_col,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_ready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  item_t              new_item;
  byte_cls_t          cls;
  logic               push;
  logic               pop;

  // Classify the byte independently of the parser mode.
  always_comb begin
    if (in_data_byte == CH_CR) begin
      cls = CLS_CR;
    end else if (in_data_byte == CH_LF) begin
      cls = CLS_LF;
    end else if (in_data_byte == CH_BS) begin
      cls = CLS_BS;
    end else if (in_data_byte == CH_TAB) begin
      cls = CLS_TAB;
    end else if (in_data_byte == CH_ESC) begin
      cls = CLS_ESC;
    end else if (in_data_byte == CH_BEL) begin
      cls = CLS_BEL;
    end else if (in_data_byte < CH_SPACE) begin
      cls = CLS_CTRL;
    end else if (in_data_byte >= CH_ZERO && in_data_byte <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_data_byte == CH_SEMI) begin
      cls = CLS_SEMI;
    end else if (in_data_byte >= CH_FIN_LO && in_data_byte <= CH_FIN_HI) begin
      cls = CLS_FINAL;
    end else begin
      cls = CLS_PRINT;
    end
  end

  // Build the queue entry.
  always_comb begin
    new_item.is_read = in_req_type;
    new_item.data    = in_data_byte;
    new_item.row     = in_read_row;
    new_item.col     = in_read_col;
    new_item.cls     = cls;
  end

  // Queue handshakes.
  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: design/vtt_back.sv
// ============================================================================
// vtt_back
// Interprets queued requests: parser, cursor and the screen memory, with
// sweeps for clearing, erasing and scrolling, and the result register.
// ============================================================================
module vtt_back
  import vtt_pkg::*;
#(
  parameter int ROW_COUNT = ROW_COUNT_DEF,
  parameter int COL_COUNT = COL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic [ROW_W-1:0]  out_cursor_line,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [MODE_W-1:0] out_parse_mode
);

  localparam int RW    = $clog2(ROW_COUNT);
  localparam int CW    = $clog2(COL_COUNT + 1);
  localparam int CAW   = $clog2(COL_COUNT);
  localparam int AW    = RW + CAW;
  localparam int DEPTH = ROW_COUNT * (2 ** CAW);

  localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COL_COUNT - 1);
  localparam logic [CW-1:0] COL_END  = CW'(COL_COUNT);

  // Screen memory.
  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CHAR_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  // Control and architectural state.
  bk_state_t         state_r, state_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  mode_t             mode_r, mode_nxt;
  logic [15:0]       fp_r, fp_nxt;
  logic [15:0]       sp_r, sp_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [1:0]        pd_r, pd_nxt;
  logic              ds_r, ds_nxt;
  logic              res_pend_r;
  logic              put_pend_r;
  logic              in_range_r;

  // Sweep and write position registers.
  logic [RW-1:0]     sw_row_r;
  logic [CW-1:0]     sw_col_r;
  logic [RW-1:0]     fe_row_r;
  logic [CW-1:0]     fe_col_r;
  logic [RW-1:0]     put_row_r;
  logic [CW-1:0]     put_col_r;
  logic [CHAR_W-1:0] put_ch_r;
  logic [CHAR_W-1:0] cell_r;

  // Output register.
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_cell_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [MODE_W-1:0] out_mode_r;

  // Decoded actions of the request at the head of the queue.
  logic              act_scroll;
  logic              act_put;
  logic              act_fill;
  logic [RW-1:0]     put_row_nxt;
  logic [CW-1:0]     put_col_nxt;
  logic [RW-1:0]     fs_row_nxt;
  logic [CW-1:0]     fs_col_nxt;
  logic [RW-1:0]     fe_row_nxt;
  logic [CW-1:0]     fe_col_nxt;
  logic              rd_in_range;

  // Helpers for the decoder.
  logic              at_bottom;
  logic [RW-1:0]     row_down;
  logic [19:0]       acc_mul;
  logic [15:0]       fp_eff;
  logic [15:0]       sp_eff;
  logic [1:0]        pd_eff;
  logic [15:0]       p0;
  logic [15:0]       p1;
  logic [15:0]       n_move;
  logic [16:0]       sum_row;
  logic [16:0]       sum_col;
  logic [15:0]       home_row;
  logic [15:0]       home_col;
  logic [CW:0]       tab_base;
  logic [CW:0]       tab_stop;

  // Sweep and scroll step signals.
  logic              fill_last;
  logic              fill_we;
  logic              scr_last_col;
  logic              scr_last;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == BK_IDLE);

  assign at_bottom = (cur_row_r == ROW_LAST);
  assign row_down  = at_bottom ? cur_row_r : cur_row_r + RW'(1);

  // Decimal accumulation before saturation.
  assign acc_mul = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 20'(q_item.data[3:0]);

  // Parameters as a final byte sees them, with a trailing digit run pushed.
  always_comb begin
    fp_eff = fp_r;
    sp_eff = sp_r;
    pd_eff = pd_r;
    if (ds_r) begin
      if (pd_r == 2'd0) begin
        fp_eff = acc_r;
      end else if (pd_r == 2'd1) begin
        sp_eff = acc_r;
      end
      if (pd_r != 2'd2) begin
        pd_eff = pd_r + 2'd1;
      end
    end
    p0       = (pd_eff != 2'd0) ? fp_eff : 16'd0;
    p1       = (pd_eff == 2'd2) ? sp_eff : 16'd0;
    n_move   = (p0 != 16'd0) ? p0 : 16'd1;
    sum_row  = 17'(cur_row_r) + 17'(n_move);
    sum_col  = 17'(cur_col_r) + 17'(n_move);
    home_row = (p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
    home_col = (p1 != 16'd0) ? p1 - 16'd1 : 16'd0;
    tab_base = (CW + 1)'(cur_col_r) & ~((CW + 1)'(TAB_STOP - 1));
    tab_stop = tab_base + (CW + 1)'(TAB_STOP);
    if (tab_stop > (CW + 1)'(COL_COUNT)) begin
      tab_stop = (CW + 1)'(COL_COUNT);
    end
  end

  // Decoder: next architectural state and the memory work a request needs.
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    mode_nxt    = mode_r;
    fp_nxt      = fp_r;
    sp_nxt      = sp_r;
    acc_nxt     = acc_r;
    pd_nxt      = pd_r;
    ds_nxt      = ds_r;
    act_scroll  = 1'b0;
    act_put     = 1'b0;
    act_fill    = 1'b0;
    put_row_nxt = cur_row_r;
    put_col_nxt = cur_col_r;
    fs_row_nxt  = cur_row_r;
    fs_col_nxt  = cur_col_r;
    fe_row_nxt  = cur_row_r;
    fe_col_nxt  = COL_LAST;
    rd_in_range = (8'(q_item.row) < 8'(ROW_COUNT)) && (8'(q_item.col) < 8'(COL_COUNT));
    if (!q_item.is_read) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          case (q_item.cls)
            CLS_ESC: begin
              mode_nxt = MODE_ESC;
            end
            CLS_CR: begin
              cur_col_nxt = '0;
            end
            CLS_LF: begin
              cur_col_nxt = '0;
              cur_row_nxt = row_down;
              act_scroll  = at_bottom;
            end
            CLS_BS: begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - CW'(1);
              end
            end
            CLS_TAB: begin
              // Spaces up to the next stop; nothing while a wrap is pending.
              if (cur_col_r < COL_END) begin
                act_fill    = 1'b1;
                fe_col_nxt  = CW'(tab_stop - (CW + 1)'(1));
                cur_col_nxt = CW'(tab_stop);
              end
            end
            CLS_BEL, CLS_CTRL: begin
            end
            default: begin
              // Printable byte, with the deferred wrap taken first.
              act_put = 1'b1;
              if (cur_col_r >= COL_END) begin
                act_scroll  = at_bottom;
                put_row_nxt = row_down;
                put_col_nxt = '0;
                cur_row_nxt = row_down;
                cur_col_nxt = CW'(1);
              end else begin
                cur_col_nxt = cur_col_r + CW'(1);
              end
            end
          endcase
        end
        MODE_ESC: begin
          if (q_item.data == CH_LBRACK) begin
            mode_nxt = MODE_CSI;
            fp_nxt   = '0;
            sp_nxt   = '0;
            acc_nxt  = '0;
            pd_nxt   = '0;
            ds_nxt   = 1'b0;
          end else if (q_item.data == CH_RBRACK) begin
            mode_nxt = MODE_OSC;
          end else begin
            if (q_item.data == CH_LC_C) begin
              act_fill    = 1'b1;
              fs_row_nxt  = '0;
              fs_col_nxt  = '0;
              fe_row_nxt  = ROW_LAST;
              cur_row_nxt = '0;
              cur_col_nxt = '0;
            end
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_OSC: begin
          if (q_item.cls == CLS_BEL) begin
            mode_nxt = MODE_NORMAL;
          end else if (q_item.cls == CLS_ESC) begin
            mode_nxt = MODE_ESC;
          end
        end
        MODE_CSI: begin
          case (q_item.cls)
            CLS_DIGIT: begin
              acc_nxt = (acc_mul > 20'(PARAM_MAX)) ? PARAM_MAX : acc_mul[15:0];
              ds_nxt  = 1'b1;
            end
            CLS_SEMI: begin
              if (pd_r == 2'd0) begin
                fp_nxt = acc_r;
              end else if (pd_r == 2'd1) begin
                sp_nxt = acc_r;
              end
              if (pd_r != 2'd2) begin
                pd_nxt = pd_r + 2'd1;
              end
              acc_nxt = '0;
              ds_nxt  = 1'b0;
            end
            CLS_FINAL: begin
              mode_nxt = MODE_NORMAL;
              fp_nxt   = fp_eff;
              sp_nxt   = sp_eff;
              pd_nxt   = pd_eff;
              acc_nxt  = ds_r ? 16'd0 : acc_r;
              ds_nxt   = 1'b0;
              case (q_item.data)
                CH_UP: begin
                  cur_row_nxt = (n_move > 16'(cur_row_r)) ? '0 : RW'(16'(cur_row_r) - n_move);
                end
                CH_DOWN: begin
                  cur_row_nxt = (sum_row >= 17'(ROW_COUNT)) ? ROW_LAST : RW'(sum_row);
                end
                CH_RIGHT: begin
                  cur_col_nxt = (sum_col >= 17'(COL_COUNT)) ? COL_LAST : CW'(sum_col);
                end
                CH_LEFT: begin
                  cur_col_nxt = (n_move > 16'(cur_col_r)) ? '0 : CW'(16'(cur_col_r) - n_move);
                end
                CH_HOME, CH_HOME_F: begin
                  cur_row_nxt = (home_row >= 16'(ROW_COUNT)) ? ROW_LAST : RW'(home_row);
                  cur_col_nxt = (home_col >= 16'(COL_COUNT)) ? COL_LAST : CW'(home_col);
                end
                CH_ERASE: begin
                  if (p0 == 16'd2 || p0 == 16'd3) begin
                    act_fill    = 1'b1;
                    fs_row_nxt  = '0;
                    fs_col_nxt  = '0;
                    fe_row_nxt  = ROW_LAST;
                    cur_row_nxt = '0;
                    cur_col_nxt = '0;
                  end else if (p0 == 16'd0) begin
                    act_fill   = 1'b1;
                    fe_row_nxt = ROW_LAST;
                  end
                end
                CH_ERLINE: begin
                  if (p0 == 16'd0) begin
                    act_fill = 1'b1;
                  end else if (p0 == 16'd1) begin
                    // Erase to the cursor; a pending wrap stops at the last column.
                    act_fill   = 1'b1;
                    fs_col_nxt = '0;
                    fe_col_nxt = (cur_col_r < COL_END) ? cur_col_r : COL_LAST;
                  end else if (p0 == 16'd2) begin
                    act_fill   = 1'b1;
                    fs_col_nxt = '0;
                  end
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Sweep and scroll step conditions.
  assign fill_we      = (sw_col_r < COL_END);
  assign fill_last    = (sw_row_r == fe_row_r) && (sw_col_r >= fe_col_r);
  assign scr_last_col = (sw_col_r == COL_LAST);
  assign scr_last     = scr_last_col && (sw_row_r == ROW_LAST - RW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_item.is_read) begin
            state_nxt = BK_RDDATA;
          end else if (act_scroll) begin
            state_nxt = BK_SCRRD;
          end else if (act_fill) begin
            state_nxt = BK_FILL;
          end else if (act_put) begin
            state_nxt = BK_PUT;
          end else begin
            state_nxt = BK_DONE;
          end
        end
      end
      BK_RDDATA: begin
        state_nxt = BK_DONE;
      end
      BK_SCRRD: begin
        state_nxt = BK_SCRWR;
      end
      BK_SCRWR: begin
        state_nxt = scr_last ? BK_FILL : BK_SCRRD;
      end
      BK_FILL: begin
        if (fill_last) begin
          if (put_pend_r) begin
            state_nxt = BK_PUT;
          end else if (res_pend_r) begin
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_PUT: begin
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Memory port control per state.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {sw_row_r, sw_col_r[CAW-1:0]};
    mem_wd = CH_SPACE;
    mem_ra = {RW'(q_item.row), CAW'(q_item.col)};
    unique case (state_r)
      BK_SCRRD: begin
        mem_ra = {sw_row_r + RW'(1), sw_col_r[CAW-1:0]};
      end
      BK_SCRWR: begin
        mem_we = 1'b1;
        mem_wd = mem_q;
      end
      BK_FILL: begin
        mem_we = fill_we;
      end
      BK_PUT: begin
        mem_we = 1'b1;
        mem_wa = {put_row_r, put_col_r[CAW-1:0]};
        mem_wd = put_ch_r;
      end
      default: begin
      end
    endcase
  end

  // Screen memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Control state; reset starts the clearing pass over the whole screen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      mode_r      <= MODE_NORMAL;
      fp_r        <= '0;
      sp_r        <= '0;
      acc_r       <= '0;
      pd_r        <= '0;
      ds_r        <= 1'b0;
      res_pend_r  <= 1'b0;
      put_pend_r  <= 1'b0;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      fe_row_r    <= ROW_LAST;
      fe_col_r    <= COL_LAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The result register fills from the done state and empties on a handshake.
      if (state_r == BK_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        BK_IDLE: begin
          if (q_valid) begin
            cur_row_r  <= cur_row_nxt;
            cur_col_r  <= cur_col_nxt;
            mode_r     <= mode_nxt;
            fp_r       <= fp_nxt;
            sp_r       <= sp_nxt;
            acc_r      <= acc_nxt;
            pd_r       <= pd_nxt;
            ds_r       <= ds_nxt;
            res_pend_r <= 1'b1;
            put_pend_r <= act_put;
            if (act_scroll) begin
              sw_row_r <= '0;
              sw_col_r <= '0;
            end else begin
              sw_row_r <= fs_row_nxt;
              sw_col_r <= fs_col_nxt;
              fe_row_r <= fe_row_nxt;
              fe_col_r <= fe_col_nxt;
            end
          end
        end
        BK_SCRWR: begin
          // Copy one cell up; after the last one, blank the bottom row.
          if (scr_last) begin
            sw_row_r <= ROW_LAST;
            sw_col_r <= '0;
            fe_row_r <= ROW_LAST;
            fe_col_r <= COL_LAST;
          end else if (scr_last_col) begin
            sw_row_r <= sw_row_r + RW'(1);
            sw_col_r <= '0;
          end else begin
            sw_col_r <= sw_col_r + CW'(1);
          end
        end
        BK_FILL: begin
          if (!fill_last) begin
            if (sw_col_r >= COL_LAST) begin
              sw_row_r <= sw_row_r + RW'(1);
              sw_col_r <= '0;
            end else begin
              sw_col_r <= sw_col_r + CW'(1);
            end
          end
        end
        BK_PUT: begin
          put_pend_r <= 1'b0;
        end
        BK_DONE: begin
          if (out_free) begin
            res_pend_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid) begin
      put_row_r  <= put_row_nxt;
      put_col_r  <= put_col_nxt;
      put_ch_r   <= q_item.data;
      in_range_r <= rd_in_range;
      cell_r     <= '0;
    end
    if (state_r == BK_RDDATA) begin
      cell_r <= in_range_r ? mem_q : '0;
    end
    if (state_r == BK_DONE && out_free) begin
      out_cell_r <= cell_r;
      out_row_r  <= ROW_W'(cur_row_r);
      out_col_r  <= COL_W'(cur_col_r);
      out_mode_r <= mode_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_cell_r;
  assign out_cursor_line   = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_parse_mode    = out_mode_r;

endmodule

FILE: design/vt100_subset_text_terminal.sv
// ============================================================================
// vt100_subset_text_terminal
// Text terminal for a subset of the VT100 escape scheme, keeping a
// ROW_COUNT by COL_COUNT character grid in an on-chip memory.
// ============================================================================
// Each request on the in_ channel either interprets one host byte
// (in_req_type low) or reads one screen cell (in_req_type high). Every
// request produces exactly one result on the out_ channel: the cell
// character (zero for host bytes), the cursor position after the request
// and the parser mode. Both channels use valid/ready handshakes.
// A two-entry queue separates the byte classifier from the interpreter.
// Ordinary bytes and cursor moves go from the head of the queue to the
// done state and then to the result register; cell reads pass a memory
// read state first, and printing a character a memory write state.
// Erases walk the memory one cell per cycle: up to one row for tab and
// line erases, up to ROW_COUNT*COL_COUNT for screen clears. A scroll
// copies every cell up, reading then writing it, and blanks the bottom row.
// After reset a clearing pass writes spaces into all ROW_COUNT*COL_COUNT
// cells, one per cycle; requests queue up meanwhile and are taken after.
// While the receiver stalls, the finished result waits in the output
// register; the next request is worked on and waits at its end.
module vt100_subset_text_terminal
  import vtt_pkg::*;
#(
  parameter int ROW_COUNT = ROW_COUNT_DEF,
  parameter int COL_COUNT = COL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [CHAR_W-1:0] in_data_byte,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic [COL_W-1:0]  in_read_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic [ROW_W-1:0]  out_cursor_line,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [MODE_W-1:0] out_parse_mode
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Request intake and classification.
  vtt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_ready      (q_ready)
  );

  // Interpreter, screen memory and result register.
  vtt_back #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_ready           (q_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_char     (out_cell_char),
    .out_cursor_line   (out_cursor_line),
    .out_cursor_column (out_cursor_column),
    .out_parse_mode    (out_parse_mode)
  );

endmodule

FILE: dv/vtt_checker.sv
// ----------------------------------------------------------------------------
// vtt_checker
// Watches both channels of the text terminal, keeps its own copy of the
// screen, cursor and escape parser, and compares every result it sees
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module vtt_checker
  import vtt_pkg::*;
#(
  parameter int ROWS = ROW_COUNT_DEF,
  parameter int COLS = COL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_req_type,
  input  logic [CHAR_W-1:0] in_data_byte,
  input  logic [ROW_W-1:0]  in_read_row,
  input  logic [COL_W-1:0]  in_read_col,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CHAR_W-1:0] out_cell_char,
  input  logic [ROW_W-1:0]  out_cursor_line,
  input  logic [COL_W-1:0]  out_cursor_column,
  input  logic [MODE_W-1:0] out_parse_mode,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  line;
    logic [COL_W-1:0]  column;
    logic [MODE_W-1:0] mode;
  } term_result_t;

  // Predicted terminal state.
  logic [7:0]  grid [ROWS][COLS];
  int          cur_row;
  int          cur_col;
  mode_t       mode;
  int          par0;
  int          par1;
  int          accum;
  int          nparams;
  bit          have_digit;
  term_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic void blank_from(int r, int c);
    for (int k = c; k < COLS; k++) grid[r][k] = CH_SPACE;
  endfunction

  function automatic void blank_all();
    for (int r = 0; r < ROWS; r++) blank_from(r, 0);
  endfunction

  function automatic void next_line();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int k = 0; k < COLS; k++) grid[r][k] = grid[r+1][k];
      blank_from(ROWS - 1, 0);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void place_glyph(logic [7:0] ch);
    if (cur_col >= COLS) begin
      cur_col = 0;
      next_line();
    end
    grid[cur_row][cur_col] = ch;
    cur_col++;
  endfunction

  function automatic void close_param();
    if (nparams == 0) par0 = accum;
    else if (nparams == 1) par1 = accum;
    if (nparams < 2) nparams++;
    accum = 0;
    have_digit = 0;
  endfunction

  // Acts on a CSI final byte with the parameters gathered so far.
  function automatic void do_csi(logic [7:0] fin);
    int p0, p1, n, last;
    if (have_digit) close_param();
    p0 = (nparams >= 1) ? par0 : 0;
    p1 = (nparams >= 2) ? par1 : 0;
    n = (p0 != 0) ? p0 : 1;
    case (fin)
      CH_UP: cur_row = (n > cur_row) ? 0 : cur_row - n;
      CH_DOWN: cur_row = (cur_row + n >= ROWS) ? ROWS - 1 : cur_row + n;
      CH_RIGHT: cur_col = (cur_col + n >= COLS) ? COLS - 1 : cur_col + n;
      CH_LEFT: cur_col = (n > cur_col) ? 0 : cur_col - n;
      CH_HOME, CH_HOME_F: begin
        cur_row = (p0 > 0) ? p0 - 1 : 0;
        cur_col = (p1 > 0) ? p1 - 1 : 0;
        if (cur_row >= ROWS) cur_row = ROWS - 1;
        if (cur_col >= COLS) cur_col = COLS - 1;
      end
      CH_ERASE: begin
        if (p0 == 2 || p0 == 3) begin
          blank_all();
          cur_row = 0;
          cur_col = 0;
        end else if (p0 == 0) begin
          blank_from(cur_row, cur_col);
          for (int r = cur_row + 1; r < ROWS; r++) blank_from(r, 0);
        end
      end
      CH_ERLINE: begin
        if (p0 == 0) blank_from(cur_row, cur_col);
        else if (p0 == 1) begin
          last = (cur_col < COLS) ? cur_col : COLS - 1;
          for (int k = 0; k <= last; k++) grid[cur_row][k] = CH_SPACE;
        end else if (p0 == 2) blank_from(cur_row, 0);
      end
      default: ;
    endcase
  endfunction

  function automatic void interpret_byte(logic [7:0] b);
    int stop;
    case (mode)
      MODE_NORMAL: begin
        if (b == CH_ESC) mode = MODE_ESC;
        else if (b == CH_CR) cur_col = 0;
        else if (b == CH_LF) begin
          cur_col = 0;
          next_line();
        end else if (b == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (b == CH_TAB) begin
          stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
          if (stop > COLS) stop = COLS;
          while (cur_col < stop) place_glyph(CH_SPACE);
        end else if (b >= CH_SPACE) place_glyph(b);
      end
      MODE_ESC: begin
        if (b == CH_LBRACK) begin
          mode = MODE_CSI;
          par0 = 0;
          par1 = 0;
          accum = 0;
          nparams = 0;
          have_digit = 0;
        end else if (b == CH_RBRACK) mode = MODE_OSC;
        else begin
          if (b == CH_LC_C) begin
            blank_all();
            cur_row = 0;
            cur_col = 0;
          end
          mode = MODE_NORMAL;
        end
      end
      MODE_OSC: begin
        if (b == CH_BEL) mode = MODE_NORMAL;
        else if (b == CH_ESC) mode = MODE_ESC;
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          accum = accum * 10 + (b - CH_ZERO);
          if (accum > PARAM_MAX) accum = PARAM_MAX;
          have_digit = 1;
        end else if (b == CH_SEMI) close_param();
        else if (b >= CH_FIN_LO && b <= CH_FIN_HI) begin
          do_csi(b);
          mode = MODE_NORMAL;
        end
      end
    endcase
  endfunction

  // Prediction on each accepted request, comparison on each result.
  always @(posedge clk) begin
    term_result_t want;
    term_result_t got;
    if (!rst_n) begin
      blank_all();
      cur_row = 0;
      cur_col = 0;
      mode = MODE_NORMAL;
      par0 = 0;
      par1 = 0;
      accum = 0;
      nparams = 0;
      have_digit = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        want.ch = '0;
        if (!in_req_type) interpret_byte(in_data_byte);
        else if (in_read_row < ROWS && in_read_col < COLS)
          want.ch = grid[in_read_row][in_read_col];
        want.line = cur_row[ROW_W-1:0];
        want.column = cur_col[COL_W-1:0];
        want.mode = mode;
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_cell_char, out_cursor_line, out_cursor_column, out_parse_mode};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.ch !== want.ch)
            $display("%0t: cell_char expected %h actual %h", $time, want.ch, got.ch);
          if (got.line !== want.line)
            $display("%0t: cursor_line expected %0d actual %0d", $time, want.line,
                     got.line);
          if (got.column !== want.column)
            $display("%0t: cursor_column expected %0d actual %0d", $time,
                     want.column, got.column);
          if (got.mode !== want.mode)
            $display("%0t: parse_mode expected %0d actual %0d", $time, want.mode,
                     got.mode);
          if (got !== want) fail_count++;
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives escape sequences, text and cell reads into the text terminal with
// random gaps on both channels, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
  import vtt_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = 1'b0;
  logic [CHAR_W-1:0] in_data_byte = '0;
  logic [ROW_W-1:0]  in_read_row = '0;
  logic [COL_W-1:0]  in_read_col = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ROW_W-1:0]  out_cursor_line;
  logic [COL_W-1:0]  out_cursor_column;
  logic [MODE_W-1:0] out_parse_mode;
  int                fail_count;
  int                pending_count;
  bit                hold_off = 1'b0;

  always #2 clk = ~clk;

  vt100_subset_text_terminal u_dut (.*);

  vtt_checker u_checker (.*);

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offers one request and returns at the edge that accepts it; valid stays
  // high so that a following request can take over without a gap.
  task automatic send_request(bit rd, logic [7:0] b, logic [3:0] r, logic [5:0] c);
    in_valid <= 1'b1;
    in_req_type <= rd;
    in_data_byte <= b;
    in_read_row <= r;
    in_read_col <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain_sender();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
  endtask

  task automatic send_byte(logic [7:0] b, bit paced);
    int g;
    send_request(1'b0, b, 4'($urandom), 6'($urandom));
    if (paced) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic send_read(logic [3:0] r, logic [5:0] c);
    send_request(1'b1, 8'($urandom), r, c);
  endtask

  task automatic send_csi(int p0, int p1, int np, logic [7:0] fin);
    string s0;
    string s1;
    s0 = $sformatf("%0d", p0);
    s1 = $sformatf("%0d", p1);
    send_byte(CH_ESC, 1);
    send_byte(CH_LBRACK, 1);
    if (np >= 1) begin
      if (p0 >= 0) for (int i = 0; i < s0.len(); i++) send_byte(s0[i], 1);
    end
    if (np >= 2) begin
      send_byte(CH_SEMI, 1);
      if (p1 >= 0) for (int i = 0; i < s1.len(); i++) send_byte(s1[i], 1);
    end
    send_byte(fin, 1);
  endtask

  function automatic logic [7:0] pick_final();
    logic [7:0] finals [9] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_HOME, CH_HOME_F,
                              CH_ERASE, CH_ERLINE, 8'h6D};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(CH_FIN_LO, CH_FIN_HI));
    return finals[$urandom_range(0, 8)];
  endfunction

  function automatic int pick_param();
    case ($urandom_range(0, 5))
      0: return -1;
      1: return $urandom_range(0, 3);
      2: return $urandom_range(0, 99999);
      default: return $urandom_range(0, 50);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: text, controls, escapes, extremes.
    send_read(4'd0, 6'd0);
    send_byte(8'h41, 1);
    send_byte(8'hFF, 1);
    send_byte(CH_TAB, 1);
    send_byte(CH_BS, 1);
    send_byte(8'h01, 1);
    send_csi(1, 45, 2, CH_HOME);
    send_byte(8'h7F, 0);
    send_byte(8'h80, 0);
    send_byte(CH_TAB, 0);
    send_csi(1, -1, 1, CH_ERLINE);
    send_read(4'd15, 6'd63);
    send_read(4'd11, 6'd44);
    send_byte(CH_LF, 1);

    // Sender pauses until everything has come back.
    drain_sender();
    repeat (20) @(posedge clk);

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1'b1;
    repeat (12) send_byte(8'h61, 0);

    for (int n = 0; n < 460; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) send_byte(8'($urandom_range(CH_SPACE, CH_FIN_HI)), 1);
      else if (kind < 45) send_byte(8'($urandom), 1);
      else if (kind < 55) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_CR, 1);
          1: send_byte(CH_LF, 1);
          2: send_byte(CH_BS, 1);
          default: send_byte(CH_TAB, 1);
        endcase
      end else if (kind < 75) send_csi(pick_param(), pick_param(), $urandom_range(0, 2),
                                       pick_final());
      else if (kind < 90) send_read(4'($urandom_range(0, 12)), 6'($urandom_range(0, 46)));
      else if (kind < 93) begin
        send_byte(CH_ESC, 1);
        send_byte(CH_RBRACK, 1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1);
        send_byte($urandom_range(0, 1) ? CH_BEL : CH_ESC, 1);
      end else if (kind < 95) begin
        send_byte(CH_ESC, 1);
        send_byte($urandom_range(0, 1) ? CH_LC_C : 8'($urandom), 1);
      end else if (kind < 97) begin
        // Broken or overlong sequence.
        send_byte(CH_ESC, 1);
        send_byte(CH_LBRACK, 1);
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 8'h3F)), 1);
      end else if (kind < 98) send_csi($urandom_range(0, 3), -1, 1, CH_ERASE);
      else send_read(4'($urandom), 6'($urandom));
    end

    drain_sender();
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
design/vtt_pkg.sv
design/vtt_front.sv
design/vtt_back.sv
design/vt100_subset_text_terminal.sv
dv/vtt_checker.sv
dv/testbench.sv
